// File: src/mouse_axis_residual_quantizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MOUSE_AXIS_RESIDUAL_QUANTIZER_UNIT_ASSERT_SVH
`define MOUSE_AXIS_RESIDUAL_QUANTIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define MARQ_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("marq: same-cycle check failed");

// next-cycle implication
`define MARQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("marq: next-cycle check failed");

`endif

// File: src/marq_pkg.sv
// ----------------------------------------------------------------------------
// marq_pkg
// Widths, register codes, states and shared types of the axis quantizer.
// ----------------------------------------------------------------------------
package marq_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GAIN_FRAC  = 16;
    localparam int DELTA_W    = 32;
    localparam int TIME_W     = 20;
    localparam int GAIN_W     = 24;
    localparam int MAXM_W     = 15;
    localparam int COUNT_W    = 16;
    localparam int RES_W      = FRAC_BITS + 1;

    localparam int MCAND_W    = 48;
    localparam int MPLIER_W   = GAIN_W;
    localparam int PROD_W     = MCAND_W + MPLIER_W;
    localparam int MUL_CNT_W  = $clog2(MPLIER_W + 1);

    // magnitudes at or above 2^QB always saturate
    localparam int QB         = FRAC_BITS + 18;
    localparam int MAG_W      = QB + 1;
    localparam int DVD_W      = MCAND_W + TIME_W;
    localparam int HI_W       = DVD_W - QB;
    localparam int DIV_CNT_W  = $clog2(QB + 1);
    localparam int SC_W       = MAG_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [MAG_W-1:0]  MAG_SAT  = {1'b1, {QB{1'b0}}};
    localparam logic [GAIN_W-1:0] SENS_RST = GAIN_W'(65536);
    localparam logic [GAIN_W-1:0] UPC_RST  = GAIN_W'(65536);
    localparam logic [TIME_W-1:0] REF_RST  = '0;
    localparam logic [MAXM_W-1:0] MAX_RST  = MAXM_W'(32767);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS = 2'd0,
        REG_UPC  = 2'd1,
        REG_REF  = 2'd2,
        REG_MAX  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV,
        ST_SUM,
        ST_QUANT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: src/marq_mul.sv
// ----------------------------------------------------------------------------
// marq_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module marq_mul
    import marq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [MCAND_W-1:0]  mcand,
    input  logic [MPLIER_W-1:0] mplier,
    output logic [PROD_W-1:0]   product,
    output unit_stat_t          stat
);

    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [MCAND_W-1:0]   mcand_reg, mcand_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [MCAND_W:0]     sum;
    logic                 busy;

    always_comb begin
        busy       = (cnt_reg != '0);
        sum        = {1'b0, acc_reg[PROD_W-1:MPLIER_W]}
                   + ({(MCAND_W+1){acc_reg[0]}} & {1'b0, mcand_reg});
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (start) begin
            acc_next   = {{MCAND_W{1'b0}}, mplier};
            mcand_next = mcand;
            cnt_next   = MUL_CNT_W'(MPLIER_W);
        end else if (busy) begin
            acc_next  = {sum, acc_reg[MPLIER_W-1:1]};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == MUL_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign product   = acc_reg;
    assign stat.busy = busy;
    assign stat.done = done_reg;

endmodule

// File: src/marq_div.sv
// ----------------------------------------------------------------------------
// marq_div
// Restoring divider, one quotient bit per cycle, with early saturation.
// ----------------------------------------------------------------------------
module marq_div
    import marq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [TIME_W-1:0]  divisor,
    output logic [QB-1:0]      quotient,
    output logic               sat,
    output unit_stat_t         stat
);

    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [TIME_W-1:0]    dvs_reg, dvs_next;
    logic [QB-1:0]        quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 sat_reg, sat_next;
    logic                 done_reg, done_next;
    logic [HI_W-1:0]      hi;
    logic                 hi_ge;
    logic [TIME_W:0]      trial, diff;
    logic                 ge, busy;

    always_comb begin
        busy     = (cnt_reg != '0);
        hi       = dividend[DVD_W-1:QB];
        hi_ge    = (hi >= {{(HI_W-TIME_W){1'b0}}, divisor});
        trial    = {rem_reg, quo_reg[QB-1]};
        ge       = (trial >= {1'b0, dvs_reg});
        diff     = trial - {1'b0, dvs_reg};
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        sat_next = sat_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = hi[TIME_W-1:0];
            quo_next  = dividend[QB-1:0];
            dvs_next  = divisor;
            sat_next  = hi_ge;
            cnt_next  = hi_ge ? '0 : DIV_CNT_W'(QB);
            done_next = hi_ge;
        end else if (busy) begin
            rem_next  = ge ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            quo_next  = {quo_reg[QB-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign quotient  = quo_reg;
    assign sat       = sat_reg;
    assign stat.busy = busy;
    assign stat.done = done_reg;

endmodule

// File: src/mouse_axis_residual_quantizer_unit.sv
// ----------------------------------------------------------------------------
// mouse_axis_residual_quantizer_unit
// Scales one axis motion delta per transfer and emits a saturated count,
// carrying the fractional residual to the next transfer.
// Input channel s_*: delta (Q16.16), frame_time_us, invalid. Output m_count.
// Config: cfg_we/cfg_index/cfg_wdata write one register per cycle; the user
// must write only while idle, which the block itself does not enforce. An
// invalid item goes straight to quantization. Without time normalization the
// delta takes the two gain products in the bit-serial multiplier; with it, a
// third product and a restoring divide follow, the divide ending early when
// it saturates. s_ready returns high at the edge that loads the result, so
// one item is in flight at a time.
// Reset restores the register defaults and clears the residual.
// A stalled receiver holds the result in the output register; a finished
// item waits in its final step until that register frees.
// ----------------------------------------------------------------------------
`include "mouse_axis_residual_quantizer_unit_assert.svh"

module mouse_axis_residual_quantizer_unit
    import marq_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [DELTA_W-1:0] s_delta,
    input  logic [TIME_W-1:0]         s_frame_time_us,
    input  logic                      s_invalid,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COUNT_W-1:0] m_count
);

    state_t state_reg, state_next;

    logic [GAIN_W-1:0]  sens_reg, sens_next;
    logic [GAIN_W-1:0]  upc_reg, upc_next;
    logic [TIME_W-1:0]  ref_reg, ref_next;
    logic [MAXM_W-1:0]  max_reg, max_next;

    logic               neg_reg, neg_next;
    logic [TIME_W-1:0]  fr_reg, fr_next;
    logic               inv_reg, inv_next;
    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic signed [SC_W-1:0]  sc_reg, sc_next;
    logic signed [RES_W-1:0] residual_reg, residual_next;
    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               mul_start;
    logic [MCAND_W-1:0] mul_mcand;
    logic [MPLIER_W-1:0] mul_mplier;
    logic [PROD_W-1:0]  mul_product;
    unit_stat_t         mul_stat;

    logic               div_start;
    logic [QB-1:0]      div_quotient;
    logic               div_sat;
    unit_stat_t         div_stat;

    logic [DELTA_W-1:0] d_mag;
    logic [GAIN_W-1:0]  sens_mag, upc_mag;
    logic [MCAND_W-1:0] m_gain;
    logic [MAG_W-1:0]   m_gain_clamp;
    logic signed [SC_W-1:0] mag_s, res_s, lim_s, sc_sum;
    logic [SC_W-1:0]    sc_abs;
    logic [MAXM_W-1:0]  mx, q_mag;
    logic [FRAC_BITS-1:0] r_mag;
    logic [COUNT_W-1:0] mx_ext, q_ext, q_count;
    logic [RES_W-1:0]   q_res;
    logic               sat_pos, sat_neg;

    marq_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .product (mul_product),
        .stat    (mul_stat)
    );

    marq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_product[DVD_W-1:0]),
        .divisor  (fr_reg),
        .quotient (div_quotient),
        .sat      (div_sat),
        .stat     (div_stat)
    );

    // configuration registers
    always_comb begin
        sens_next = sens_reg;
        upc_next  = upc_reg;
        ref_next  = ref_reg;
        max_next  = max_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                REG_SENS: sens_next = cfg_wdata[GAIN_W-1:0];
                REG_UPC:  upc_next  = cfg_wdata[GAIN_W-1:0];
                REG_REF:  ref_next  = cfg_wdata[TIME_W-1:0];
                REG_MAX:  max_next  = cfg_wdata[MAXM_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= SENS_RST;
            upc_reg  <= UPC_RST;
            ref_reg  <= REF_RST;
            max_reg  <= MAX_RST;
        end else begin
            sens_reg <= sens_next;
            upc_reg  <= upc_next;
            ref_reg  <= ref_next;
            max_reg  <= max_next;
        end
    end

    // operand magnitudes, gain result and final quantization
    always_comb begin
        d_mag    = s_delta[DELTA_W-1] ? (~s_delta + 1'b1) : s_delta;
        sens_mag = sens_reg[GAIN_W-1] ? (~sens_reg + 1'b1) : sens_reg;
        upc_mag  = upc_reg[GAIN_W-1] ? (~upc_reg + 1'b1) : upc_reg;

        m_gain       = mul_product[GAIN_FRAC +: MCAND_W];
        m_gain_clamp = (|m_gain[MCAND_W-1:QB]) ? MAG_SAT : {1'b0, m_gain[QB-1:0]};

        mag_s  = $signed({2'b00, mag_reg});
        if (neg_reg) begin
            mag_s = -mag_s;
        end
        res_s  = {{(SC_W-RES_W){residual_reg[RES_W-1]}}, residual_reg};
        sc_sum = mag_s + res_s;

        mx      = (max_reg == '0) ? MAXM_W'(1) : max_reg;
        lim_s   = $signed({{(SC_W-MAXM_W-FRAC_BITS){1'b0}}, mx, {FRAC_BITS{1'b0}}});
        sat_pos = (sc_reg >= lim_s);
        sat_neg = (sc_reg <= -lim_s);
        sc_abs  = sc_reg[SC_W-1] ? (~sc_reg + 1'b1) : sc_reg;
        q_mag   = sc_abs[FRAC_BITS +: MAXM_W];
        r_mag   = sc_abs[FRAC_BITS-1:0];
        mx_ext  = {1'b0, mx};
        q_ext   = {1'b0, q_mag};

        if (sat_pos) begin
            q_count = mx_ext;
            q_res   = '0;
        end else if (sat_neg) begin
            q_count = ~mx_ext + 1'b1;
            q_res   = '0;
        end else if (sc_reg[SC_W-1]) begin
            q_count = ~q_ext + 1'b1;
            q_res   = ~{1'b0, r_mag} + 1'b1;
        end else begin
            q_count = q_ext;
            q_res   = {1'b0, r_mag};
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        fr_next        = fr_reg;
        inv_next       = inv_reg;
        mag_next       = mag_reg;
        sc_next        = sc_reg;
        residual_next  = residual_reg;
        out_valid_next = out_valid_reg && !m_ready;
        count_next     = count_reg;
        mul_start      = 1'b0;
        mul_mcand      = m_gain;
        mul_mplier     = upc_mag;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next = s_delta[DELTA_W-1] ^ sens_reg[GAIN_W-1] ^ upc_reg[GAIN_W-1];
                    fr_next  = s_frame_time_us;
                    inv_next = s_invalid;
                    if (s_invalid) begin
                        state_next = ST_QUANT;
                    end else begin
                        mul_start  = 1'b1;
                        mul_mcand  = MCAND_W'(d_mag);
                        mul_mplier = sens_mag;
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                if (mul_stat.done) begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2: begin
                if (mul_stat.done) begin
                    if (ref_reg != '0 && fr_reg != '0) begin
                        mul_start  = 1'b1;
                        mul_mplier = MPLIER_W'(ref_reg);
                        state_next = ST_MUL3;
                    end else begin
                        mag_next   = m_gain_clamp;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_MUL3: begin
                if (mul_stat.done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    mag_next   = div_sat ? MAG_SAT : {1'b0, div_quotient};
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                sc_next    = sc_sum;
                state_next = ST_QUANT;
            end
            ST_QUANT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    count_next     = inv_reg ? '0 : q_count;
                    residual_next  = inv_reg ? '0 : $signed(q_res);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            residual_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            residual_reg  <= residual_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        fr_reg    <= fr_next;
        inv_reg   <= inv_next;
        mag_reg   <= mag_next;
        sc_reg    <= sc_next;
        count_reg <= count_next;
    end

    assign m_valid = out_valid_reg;
    assign m_count = count_reg;

    `MARQ_ASSERT_IMPLIES(a_mul_start_free, mul_start, !mul_stat.busy)
    `MARQ_ASSERT_IMPLIES(a_div_start_free, div_start, !div_stat.busy && !mul_stat.busy)
    `MARQ_ASSERT_NEXT(a_invalid_direct, s_valid && s_ready && s_invalid, state_reg == ST_QUANT)
    `MARQ_ASSERT_IMPLIES(a_out_from_quant, $rose(out_valid_reg), $past(state_reg) == ST_QUANT)

endmodule
